// ----- src/hbridge_signed_duty_meter_assert.svh -----
// Assertion macros for the H-bridge duty meter checker.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef HBRIDGE_SIGNED_DUTY_METER_ASSERT_SVH
`define HBRIDGE_SIGNED_DUTY_METER_ASSERT_SVH

// Same-cycle implication
`define HSDM_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("hsdm check failed");

// Next-cycle implication
`define HSDM_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("hsdm check failed");

`endif

// ----- src/hsdm_pkg.sv -----
// Types and constants for the H-bridge signed duty meter.
// No dependencies; imported by the top level.
package hsdm_pkg;

    localparam int unsigned OUT_WIDTH  = 32;
    localparam int unsigned DUTY_WIDTH = 16;
    localparam int unsigned CFG_WIDTH  = 8;
    localparam int unsigned STEP_WIDTH = 4;

    localparam logic [CFG_WIDTH-1:0]  WINDOW_RESET = 8'd199;
    // One quotient bit per step: 2^15 down to 2^0
    localparam logic [STEP_WIDTH-1:0] STEP_LAST    = 4'd15;
    localparam logic [DUTY_WIDTH-1:0] DUTY_POS_MAX = 16'h7FFF;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_PIN  = 1'b1;

    typedef enum logic [1:0] {
        MODE_BRAKE,
        MODE_FORWARD,
        MODE_REVERSE
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } t_state;

    // Decode one pin pair: equal levels brake, first high forward
    function automatic t_mode decode_pair(input logic a, input logic b);
        t_mode m;
        if (a == b) begin
            m = MODE_BRAKE;
        end else if (a) begin
            m = MODE_FORWARD;
        end else begin
            m = MODE_REVERSE;
        end
        return m;
    endfunction

endpackage

// ----- src/hbridge_signed_duty_meter.sv -----
// H-bridge signed duty meter top level; uses hsdm_pkg.
// Tick and plain pin beats are accepted without a stall; input stall is low when idle.
// A window report runs sum load, 16 bit-serial quotient steps and output for each
// motor in turn, and the output step waits out downstream stall.
// Reset is synchronous, active low: window 199, all counts, levels and flags zero.
module hbridge_signed_duty_meter
    import hsdm_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_cmd,
    input  logic [1:0]                  i_pin,
    input  logic                        i_level,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [CFG_WIDTH-1:0]        i_cfg_data,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_motor,
    output logic [OUT_WIDTH-1:0]        o_forward_time,
    output logic [OUT_WIDTH-1:0]        o_brake_time,
    output logic [OUT_WIDTH-1:0]        o_reverse_time,
    output logic signed [DUTY_WIDTH-1:0] o_duty,
    output logic                        o_last
);

    localparam int unsigned SUM_WIDTH = TIME_WIDTH + 2;
    localparam int unsigned REM_WIDTH = TIME_WIDTH + 3;

    t_state                  r_state, n_state;
    logic [CFG_WIDTH-1:0]    r_window;
    logic [3:0]              r_levels;
    t_mode                   r_mode [2];
    logic [1:0]              r_seen;
    logic [TIME_WIDTH-1:0]   r_fwd [2];
    logic [TIME_WIDTH-1:0]   r_brk [2];
    logic [TIME_WIDTH-1:0]   r_rev [2];
    logic [CFG_WIDTH-1:0]    r_event_total;
    logic                    r_motor;
    logic [SUM_WIDTH-1:0]    r_total;
    logic [REM_WIDTH-1:0]    r_rem;
    logic [DUTY_WIDTH-1:0]   r_quot;
    logic                    r_neg;
    logic                    r_zero;
    logic [STEP_WIDTH-1:0]   r_step;

    logic                    in_accept;
    logic                    out_take;
    logic                    report_hit;
    logic                    div_done;
    logic [3:0]              n_levels;
    logic                    pair_m;
    logic [TIME_WIDTH-1:0]   sel_f, sel_b, sel_r;
    logic [SUM_WIDTH-1:0]    sum_all;
    logic [TIME_WIDTH-1:0]   diff_abs;
    logic                    rem_ge;
    logic [REM_WIDTH-1:0]    rem_sub;
    logic [DUTY_WIDTH-1:0]   quot_fin;
    logic [DUTY_WIDTH-1:0]   duty_fin;

    // Saturate a time count to the 32-bit output field
    function automatic logic [OUT_WIDTH-1:0] clamp_out(input logic [TIME_WIDTH-1:0] v);
        return ((v >> OUT_WIDTH) != '0) ? '1 : OUT_WIDTH'(v);
    endfunction

    assign o_stall    = (r_state != ST_IDLE);
    assign in_accept  = i_valid && !o_stall;
    assign out_take   = o_valid && !i_stall;
    assign report_hit = (r_event_total >= r_window);
    assign div_done   = (r_state == ST_DIV) && (r_step == STEP_LAST);

    // New pin levels and the pair they touch
    always_comb begin
        n_levels        = r_levels;
        n_levels[i_pin] = i_level;
        pair_m          = i_pin[1];
    end

    // Totals of the motor under report
    always_comb begin
        sel_f    = r_fwd[r_motor];
        sel_b    = r_brk[r_motor];
        sel_r    = r_rev[r_motor];
        sum_all  = SUM_WIDTH'(sel_f) + SUM_WIDTH'(sel_b) + SUM_WIDTH'(sel_r);
        diff_abs = (sel_f >= sel_r) ? (sel_f - sel_r) : (sel_r - sel_f);
    end

    // One restoring-division step per cycle
    always_comb begin
        rem_ge   = (r_rem >= REM_WIDTH'(r_total));
        rem_sub  = rem_ge ? (r_rem - REM_WIDTH'(r_total)) : r_rem;
        quot_fin = {r_quot[DUTY_WIDTH-2:0], rem_ge};
        if (r_zero) begin
            duty_fin = '0;
        end else if (!r_neg) begin
            duty_fin = quot_fin[DUTY_WIDTH-1] ? DUTY_POS_MAX : quot_fin;
        end else begin
            duty_fin = ~quot_fin + DUTY_WIDTH'(1);
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept && (i_cmd == CMD_PIN) && report_hit) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_state = r_motor ? ST_IDLE : ST_LOAD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Window register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_data;
        end
    end

    // Pin tracking, time accumulation and window clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels      <= '0;
            r_seen        <= '0;
            r_event_total <= '0;
            r_motor       <= 1'b0;
            for (int m = 0; m < 2; m++) begin
                r_mode[m] <= MODE_BRAKE;
                r_fwd[m]  <= '0;
                r_brk[m]  <= '0;
                r_rev[m]  <= '0;
            end
        end else begin
            if (in_accept && (i_cmd == CMD_TICK)) begin
                // credit the tick to the mode that held, saturating
                for (int m = 0; m < 2; m++) begin
                    if (r_seen[m]) begin
                        case (r_mode[m])
                            MODE_FORWARD: begin
                                if (r_fwd[m] != '1) r_fwd[m] <= r_fwd[m] + TIME_WIDTH'(1);
                            end
                            MODE_REVERSE: begin
                                if (r_rev[m] != '1) r_rev[m] <= r_rev[m] + TIME_WIDTH'(1);
                            end
                            default: begin
                                if (r_brk[m] != '1) r_brk[m] <= r_brk[m] + TIME_WIDTH'(1);
                            end
                        endcase
                    end
                end
            end else if (in_accept && report_hit) begin
                // report beat: consume the event, start a new window
                r_event_total <= CFG_WIDTH'(1);
                r_motor       <= 1'b0;
            end else if (in_accept) begin
                r_levels       <= n_levels;
                r_mode[pair_m] <= decode_pair(n_levels[{pair_m, 1'b0}],
                                              n_levels[{pair_m, 1'b1}]);
                r_seen[pair_m] <= 1'b1;
                r_event_total  <= r_event_total + CFG_WIDTH'(1);
            end

            if ((r_state == ST_OUT) && !i_stall) begin
                if (r_motor) begin
                    // both motors reported: clear the totals
                    for (int m = 0; m < 2; m++) begin
                        r_fwd[m] <= '0;
                        r_brk[m] <= '0;
                        r_rev[m] <= '0;
                    end
                end else begin
                    r_motor <= 1'b1;
                end
            end
        end
    end

    // Bit-serial divider: load, then shift one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_LOAD: begin
                r_total <= sum_all;
                r_rem   <= REM_WIDTH'(diff_abs);
                r_neg   <= (sel_f < sel_r);
                r_zero  <= (sum_all == '0);
                r_quot  <= '0;
                r_step  <= '0;
            end
            ST_DIV: begin
                r_rem  <= {rem_sub[REM_WIDTH-2:0], 1'b0};
                r_quot <= quot_fin;
                r_step <= r_step + STEP_WIDTH'(1);
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (div_done) begin
            o_valid <= 1'b1;
        end else if (out_take) begin
            o_valid <= 1'b0;
        end
    end

    // Result payload, held until taken
    always_ff @(posedge i_clk) begin
        if (div_done) begin
            o_motor        <= r_motor;
            o_last         <= r_motor;
            o_forward_time <= clamp_out(sel_f);
            o_brake_time   <= clamp_out(sel_b);
            o_reverse_time <= clamp_out(sel_r);
            o_duty         <= duty_fin;
        end
    end

endmodule

// ----- src/hsdm_checker.sv -----
// Port-level checks for the H-bridge signed duty meter, bound to the top level.
// Uses the macros of hbridge_signed_duty_meter_assert.svh.
`include "hbridge_signed_duty_meter_assert.svh"

module hsdm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_motor,
    input logic o_last
);

    // hold a stalled result beat
    `HSDM_ASSERT_NEXT(a_valid_holds, o_valid && i_stall, o_valid)
    // no new input while a result is pending
    `HSDM_ASSERT_NOW(a_busy_while_out, o_valid, o_stall)
    // the left motor closes the report
    `HSDM_ASSERT_NOW(a_last_is_left, o_valid, o_last == o_motor)
    // after the closing beat, the output goes quiet
    `HSDM_ASSERT_NEXT(a_idle_after_last, o_valid && !i_stall && o_last, !o_valid)
    // after the first beat, the second one is still being worked on
    `HSDM_ASSERT_NEXT(a_busy_after_first, o_valid && !i_stall && !o_last, o_stall)

endmodule

bind hbridge_signed_duty_meter hsdm_checker u_hsdm_checker (.*);

// ----- tb/tb_hbridge_signed_duty_meter.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the H-bridge signed duty meter: a window tracker mirrors the
// pin, mode and time totals and compares every report beat field by field.
// Depends on hsdm_pkg and hbridge_signed_duty_meter.

import hsdm_pkg::*;

typedef struct {
    logic                  motor;
    logic [OUT_WIDTH-1:0]  fwd;
    logic [OUT_WIDTH-1:0]  brk;
    logic [OUT_WIDTH-1:0]  rev;
    logic [DUTY_WIDTH-1:0] duty;
    logic                  last;
} motor_report_t;

// Tracks both motors' totals and the reports owed by the block
class duty_window_tracker;
    logic [CFG_WIDTH-1:0] window;
    logic [3:0]           levels;
    t_mode                mode [2];
    bit                   seen [2];
    logic [OUT_WIDTH-1:0] fwd [2];
    logic [OUT_WIDTH-1:0] brk [2];
    logic [OUT_WIDTH-1:0] rev [2];
    logic [CFG_WIDTH-1:0] events;
    motor_report_t        owed_reports [$];
    int                   mismatches;

    function new();
        window = WINDOW_RESET;
        levels = '0;
        events = '0;
        mismatches = 0;
        for (int m = 0; m < 2; m++) begin
            mode[m] = MODE_BRAKE;
            seen[m] = 1'b0;
            fwd[m]  = '0;
            brk[m]  = '0;
            rev[m]  = '0;
        end
    endfunction

    function void set_window(logic [CFG_WIDTH-1:0] value);
        window = value;
    endfunction

    // Totals and Q1.15 duty of one motor, truncated toward zero and saturated
    function motor_report_t report_of(int m);
        motor_report_t r;
        logic [63:0] f, v, total, q;
        f = 64'(fwd[m]);
        v = 64'(rev[m]);
        total = f + 64'(brk[m]) + v;
        r.motor = m[0];
        r.fwd   = fwd[m];
        r.brk   = brk[m];
        r.rev   = rev[m];
        r.last  = m[0];
        if (total == 64'd0) begin
            r.duty = '0;
        end else if (f >= v) begin
            q = ((f - v) << 15) / total;
            r.duty = (q > 64'd32767) ? DUTY_POS_MAX : q[15:0];
        end else begin
            q = ((v - f) << 15) / total;
            if (q > 64'd32768) begin
                q = 64'd32768;
            end
            q = -q;
            r.duty = q[15:0];
        end
        return r;
    endfunction

    // Advance the state by one accepted input beat
    function void take_beat(logic cmd, logic [1:0] pin, logic level);
        int m;
        logic a, b;
        if (cmd == CMD_TICK) begin
            for (m = 0; m < 2; m++) begin
                if (!seen[m]) continue;
                if (mode[m] == MODE_FORWARD) begin
                    if (fwd[m] != '1) fwd[m]++;
                end else if (mode[m] == MODE_REVERSE) begin
                    if (rev[m] != '1) rev[m]++;
                end else begin
                    if (brk[m] != '1) brk[m]++;
                end
            end
            return;
        end
        // Window full: this pin beat only reports and clears
        if (events >= window) begin
            for (m = 0; m < 2; m++) begin
                owed_reports.push_back(report_of(m));
            end
            for (m = 0; m < 2; m++) begin
                fwd[m] = '0;
                brk[m] = '0;
                rev[m] = '0;
            end
            events = CFG_WIDTH'(1);
            return;
        end
        levels[pin] = level;
        m = int'(pin[1]);
        a = levels[2 * m];
        b = levels[2 * m + 1];
        if (a == b) begin
            mode[m] = MODE_BRAKE;
        end else if (a) begin
            mode[m] = MODE_FORWARD;
        end else begin
            mode[m] = MODE_REVERSE;
        end
        seen[m] = 1'b1;
        events++;
    endfunction

    function void compare_field(string name, logic signed [63:0] want, logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Match one accepted result beat against the oldest owed report
    function void match_report(motor_report_t got);
        motor_report_t want;
        if (owed_reports.size() == 0) begin
            $error("result beat with no report owed (motor %0d)", got.motor);
            mismatches++;
            return;
        end
        want = owed_reports.pop_front();
        compare_field("motor", 64'(want.motor), 64'(got.motor));
        compare_field("forward_time", 64'(want.fwd), 64'(got.fwd));
        compare_field("brake_time", 64'(want.brk), 64'(got.brk));
        compare_field("reverse_time", 64'(want.rev), 64'(got.rev));
        compare_field("duty", 64'($signed(want.duty)), 64'($signed(got.duty)));
        compare_field("last", 64'(want.last), 64'(got.last));
    endfunction
endclass

module tb_hbridge_signed_duty_meter;

    localparam int  REPORT_CYCLES = 40;
    localparam int  HOLD_CYCLES   = 400;
    localparam real TIMEOUT_NS    = 2_000_000.0;

    localparam logic [1:0] PIN_R_FWD = 2'd0;
    localparam logic [1:0] PIN_R_REV = 2'd1;
    localparam logic [1:0] PIN_L_FWD = 2'd2;
    localparam logic [1:0] PIN_L_REV = 2'd3;

    logic                   i_clk;
    logic                   i_rst_n    = 1'b0;
    logic                   i_valid    = 1'b0;
    logic                   o_stall;
    logic                   i_cmd      = CMD_TICK;
    logic [1:0]             i_pin      = '0;
    logic                   i_level    = 1'b0;
    logic                   i_cfg_we   = 1'b0;
    logic [CFG_WIDTH-1:0]   i_cfg_data = '0;
    logic                   o_valid;
    logic                   i_stall    = 1'b0;
    logic                   o_motor;
    logic [OUT_WIDTH-1:0]   o_forward_time;
    logic [OUT_WIDTH-1:0]   o_brake_time;
    logic [OUT_WIDTH-1:0]   o_reverse_time;
    logic signed [DUTY_WIDTH-1:0] o_duty;
    logic                   o_last;

    int src_idle_pct = 16;
    int snk_idle_pct = 45;
    int hold_request = 0;
    int hold_left    = 0;

    duty_window_tracker meter = new();

    hbridge_signed_duty_meter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_pin          (i_pin),
        .i_level        (i_level),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_motor        (o_motor),
        .o_forward_time (o_forward_time),
        .o_brake_time   (o_brake_time),
        .o_reverse_time (o_reverse_time),
        .o_duty         (o_duty),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Check accepted result beats, then pick the next stall: long hold first, else random
    always @(posedge i_clk) begin
        motor_report_t got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.motor = o_motor;
            got.fwd   = o_forward_time;
            got.brk   = o_brake_time;
            got.rev   = o_reverse_time;
            got.duty  = o_duty;
            got.last  = o_last;
            meter.match_report(got);
        end
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < snk_idle_pct);
        end
    end

    // Offer one beat after a random gap and hold it until accepted
    task automatic send_beat(input logic cmd, input logic [1:0] pin, input logic level);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_pin   <= pin;
        i_level <= level;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        meter.take_beat(cmd, pin, level);
    endtask

    // Tick with junk in the ignored fields
    task automatic send_tick();
        send_beat(CMD_TICK, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endtask

    // Drop valid, wait out every owed report and any report still in flight
    task automatic settle();
        i_valid <= 1'b0;
        while (meter.owed_reports.size() != 0) @(posedge i_clk);
        repeat (REPORT_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [CFG_WIDTH-1:0] value);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        meter.set_window(value);
        i_cfg_we <= 1'b0;
    endtask

    // Random pin beats mixed with short tick bursts
    task automatic run_traffic(input int count, input int pin_pct);
        int sent;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < pin_pct) begin
                send_beat(CMD_PIN, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
                sent++;
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_tick();
                    sent++;
                end
            end
        end
    endtask

    initial begin
        int window;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Ticks before any pin event gain nothing; then walk each mode under the reset window
        send_tick();
        send_beat(CMD_PIN, PIN_R_FWD, 1'b1);
        send_tick();
        send_beat(CMD_PIN, PIN_L_REV, 1'b1);
        send_tick();
        send_beat(CMD_PIN, PIN_L_FWD, 1'b1);
        send_beat(CMD_PIN, PIN_R_FWD, 1'b0);
        run_traffic(260, 90);

        // Zero window: every pin beat reports
        write_window(8'd0);
        send_tick();
        send_beat(CMD_PIN, PIN_R_FWD, 1'b1);
        send_tick();
        send_beat(CMD_PIN, PIN_L_FWD, 1'b0);

        // Window of two: empty, full forward and full reverse reports
        write_window(8'd2);
        send_beat(CMD_PIN, PIN_R_REV, 1'b0);
        send_beat(CMD_PIN, PIN_R_FWD, 1'b1);
        send_beat(CMD_PIN, PIN_R_FWD, 1'b1);
        repeat (3) send_tick();
        send_beat(CMD_PIN, PIN_L_REV, 1'b0);
        send_beat(CMD_PIN, PIN_L_FWD, 1'b0);
        send_beat(CMD_PIN, PIN_L_FWD, 1'b0);
        send_beat(CMD_PIN, PIN_L_REV, 1'b1);
        repeat (2) send_tick();
        send_beat(CMD_PIN, PIN_R_REV, 1'b1);
        send_beat(CMD_PIN, PIN_R_REV, 1'b1);
        send_tick();
        send_beat(CMD_PIN, PIN_R_FWD, 1'b0);

        write_window(8'd1);
        run_traffic(20, 50);
        write_window(8'd255);
        run_traffic(360, 92);

        // Three idle regimes, several small windows each
        for (int regime = 0; regime < 3; regime++) begin
            if (regime == 1) begin
                src_idle_pct = 45;
                snk_idle_pct = 16;
            end else if (regime == 2) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            for (int k = 0; k < 4; k++) begin
                window = (regime == 2 && k == 0) ? 3 : $urandom_range(2, 12);
                write_window(8'(window));
                // Hold the result side off while beats keep coming
                if (regime == 2 && k == 0) begin
                    hold_request = HOLD_CYCLES;
                end
                run_traffic(95, 50);
            end
        end

        settle();
        if (meter.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
